/* rtl/core/per_class_request_limiter_unit_macros.svh */
// Assertion macros for the request limiter checker
`ifndef PER_CLASS_REQUEST_LIMITER_UNIT_MACROS_SVH
`define PER_CLASS_REQUEST_LIMITER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PCRL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PCRL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pcrl_pkg.sv */
// Package: constants, class ROM tables and controller/datapath interface types
package pcrl_pkg;

  localparam int NUM_CLASSES = 32;
  localparam int NUM_SLOTS   = 512;
  localparam int STAMP_BITS  = 32;

  localparam int CLASS_W      = $clog2(NUM_CLASSES);
  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int CLASS_CODE_W = 8;
  localparam int COUNT_W      = 7;
  localparam int LIMIT_W      = 7;
  localparam int HOLD_W       = 5;
  localparam int OPCODE_W     = 2;
  localparam int STATUS_W     = 2;
  localparam int NOW_W        = 32;

  localparam logic [OPCODE_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADMIT  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_EXPIRE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNLIMITED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd3;

  typedef struct packed {
    logic clear_step;
    logic take_item;
    logic scan_step;
    logic decide;
  } pcrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
  } pcrl_stat_t;

  function automatic logic [HOLD_W-1:0] class_hold(input logic [CLASS_W-1:0] c);
    logic [HOLD_W-1:0] h;
    case (c)
      5'd0, 5'd1, 5'd4, 5'd5, 5'd6, 5'd8, 5'd13, 5'd15,
      5'd23, 5'd24, 5'd26, 5'd27:                          h = 5'd5;
      5'd2, 5'd3, 5'd7, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20,
      5'd21, 5'd22, 5'd28, 5'd29, 5'd30, 5'd31:            h = 5'd10;
      5'd9, 5'd10, 5'd14:                                  h = 5'd20;
      5'd25:                                               h = 5'd2;
      default:                                             h = 5'd0;
    endcase
    return h;
  endfunction

  function automatic logic [LIMIT_W-1:0] class_limit(input logic [CLASS_W-1:0] c);
    logic [LIMIT_W-1:0] l;
    case (c)
      5'd1, 5'd16, 5'd18:                           l = 7'd20;
      5'd2, 5'd3, 5'd4, 5'd8, 5'd19, 5'd28, 5'd31:  l = 7'd5;
      5'd5, 5'd6, 5'd23:                            l = 7'd30;
      5'd7, 5'd13, 5'd15, 5'd17, 5'd29, 5'd30:      l = 7'd10;
      5'd9, 5'd10, 5'd14:                           l = 7'd1;
      5'd20, 5'd21, 5'd22:                          l = 7'd2;
      5'd25:                                        l = 7'd80;
      5'd26, 5'd27:                                 l = 7'd40;
      default:                                      l = 7'd0;
    endcase
    return l;
  endfunction

  // first slot owned by each class: prefix sums of the limits
  function automatic logic [SLOT_W-1:0] class_base(input logic [CLASS_W-1:0] c);
    logic [SLOT_W-1:0] b;
    case (c)
      5'd0, 5'd1: b = 9'd0;
      5'd2:       b = 9'd20;
      5'd3:       b = 9'd25;
      5'd4:       b = 9'd30;
      5'd5:       b = 9'd35;
      5'd6:       b = 9'd65;
      5'd7:       b = 9'd95;
      5'd8:       b = 9'd105;
      5'd9:       b = 9'd110;
      5'd10:      b = 9'd111;
      5'd11, 5'd12, 5'd13: b = 9'd112;
      5'd14:      b = 9'd122;
      5'd15:      b = 9'd123;
      5'd16:      b = 9'd133;
      5'd17:      b = 9'd153;
      5'd18:      b = 9'd163;
      5'd19:      b = 9'd183;
      5'd20:      b = 9'd188;
      5'd21:      b = 9'd190;
      5'd22:      b = 9'd192;
      5'd23:      b = 9'd194;
      5'd24, 5'd25: b = 9'd224;
      5'd26:      b = 9'd304;
      5'd27:      b = 9'd344;
      5'd28:      b = 9'd384;
      5'd29:      b = 9'd389;
      5'd30:      b = 9'd399;
      5'd31:      b = 9'd409;
      default:    b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/pcrl_ctrl.sv */
// Controller: clear pass, accept, expiry scan, decision and result handshake
module pcrl_ctrl import pcrl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output pcrl_cmd_t  cmd,
  input  pcrl_stat_t stat
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd.clear_step = (state == ST_CLEAR);
    cmd.take_item  = (state == ST_IDLE) && s_tvalid;
    cmd.scan_step  = (state == ST_SCAN);
    cmd.decide     = (state == ST_DECIDE) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (stat.clear_last) state_next = ST_IDLE;
      ST_IDLE:   if (s_tvalid) state_next = ST_SCAN;
      ST_SCAN:   if (stat.scan_last) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_DECIDE;
      ST_DECIDE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.decide) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/pcrl_datapath.sv */
// Datapath: slot stamp memory, class counts, expiry scan and admit decision
module pcrl_datapath import pcrl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  pcrl_cmd_t               cmd,
  output pcrl_stat_t              stat,
  input  logic [OPCODE_W-1:0]     in_opcode,
  input  logic [CLASS_CODE_W-1:0] in_class,
  input  logic [NOW_W-1:0]        in_now,
  output logic [STATUS_W-1:0]     status,
  output logic                    slot_granted,
  output logic [SLOT_W-1:0]       slot_number,
  output logic [COUNT_W-1:0]      class_in_use
);

  logic [STAMP_BITS-1:0]   mem [NUM_SLOTS];
  logic [COUNT_W-1:0]      counts [NUM_CLASSES];

  logic [OPCODE_W-1:0]     op_q;
  logic [CLASS_CODE_W-1:0] cls_q;
  logic [STAMP_BITS-1:0]   now_q;

  logic [SLOT_W-1:0]       clr_idx;
  logic [CLASS_W-1:0]      scan_cls;
  logic [LIMIT_W-1:0]      scan_off;
  logic                    rd_valid;
  logic [CLASS_W-1:0]      rd_cls;
  logic [SLOT_W-1:0]       rd_idx;
  logic [STAMP_BITS-1:0]   rd_q;
  logic                    found;
  logic [SLOT_W-1:0]       free_idx;

  logic [LIMIT_W-1:0]      scan_lim;
  logic                    scan_empty;
  logic                    scan_class_end;
  logic [SLOT_W-1:0]       scan_addr;
  logic                    scan_rd;
  logic [STAMP_BITS-1:0]   rd_hold;
  logic                    exp_fire;
  logic                    req_valid;
  logic [CLASS_W-1:0]      req_cls;
  logic [LIMIT_W-1:0]      req_lim;
  logic [CLASS_W-1:0]      cnt_addr;
  logic [COUNT_W-1:0]      cnt_rd;
  logic [STATUS_W-1:0]     dec_status;
  logic                    dec_admit;
  logic [COUNT_W-1:0]      dec_inuse;
  logic                    dec_grant;

  // scan walk: class by class, slot by slot within the class range
  assign scan_lim       = class_limit(scan_cls);
  assign scan_empty     = (scan_lim == '0);
  assign scan_class_end = scan_empty || (scan_off == scan_lim - LIMIT_W'(1));
  assign scan_addr      = class_base(scan_cls) + SLOT_W'(scan_off);
  assign scan_rd        = cmd.scan_step && !scan_empty;

  assign stat.scan_last  = scan_class_end && (scan_cls == CLASS_W'(NUM_CLASSES - 1));
  assign stat.clear_last = (clr_idx == SLOT_W'(NUM_SLOTS - 1));

  // stamp + hold <= now, without overflow
  assign rd_hold  = STAMP_BITS'(class_hold(rd_cls));
  assign exp_fire = rd_valid && (rd_q != '0) && (rd_hold <= now_q) &&
                    (rd_q <= now_q - rd_hold);

  assign req_valid = (cls_q < CLASS_CODE_W'(NUM_CLASSES));
  assign req_cls   = cls_q[CLASS_W-1:0];
  assign req_lim   = class_limit(req_cls);

  assign cnt_addr = cmd.decide ? req_cls : rd_cls;
  assign cnt_rd   = counts[cnt_addr];

  always_comb begin
    dec_status = STATUS_OK;
    dec_admit  = 1'b0;
    dec_inuse  = '0;
    if (!req_valid) begin
      dec_status = STATUS_INVALID;
    end else begin
      dec_inuse = cnt_rd;
      if (op_q inside {OP_CHECK, OP_ADMIT}) begin
        if (req_lim == '0) begin
          dec_status = STATUS_UNLIMITED;
        end else if (cnt_rd >= COUNT_W'(req_lim)) begin
          dec_status = STATUS_FULL;
        end else if (op_q == OP_ADMIT) begin
          dec_admit = 1'b1;
          dec_inuse = cnt_rd + COUNT_W'(1);
        end
      end
    end
  end

  assign dec_grant = dec_admit && found;

  // stamp memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_idx] <= '0;
    end else if (exp_fire) begin
      mem[rd_idx] <= '0;
    end else if (cmd.decide && dec_grant) begin
      mem[free_idx] <= now_q;
    end
    if (scan_rd) begin
      rd_q <= mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + SLOT_W'(1);
      end
      rd_valid <= scan_rd;
      if (exp_fire) begin
        counts[cnt_addr] <= cnt_rd - COUNT_W'(1);
      end else if (cmd.decide && dec_admit) begin
        counts[cnt_addr] <= dec_inuse;
      end
      if (cmd.take_item) begin
        found <= 1'b0;
      end else if (rd_valid && !found && req_valid && (rd_cls == req_cls) &&
                   ((rd_q == '0) || exp_fire)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op_q     <= in_opcode;
      cls_q    <= in_class;
      now_q    <= STAMP_BITS'(in_now);
      scan_cls <= '0;
      scan_off <= '0;
    end else if (cmd.scan_step) begin
      if (scan_class_end) begin
        scan_cls <= scan_cls + CLASS_W'(1);
        scan_off <= '0;
      end else begin
        scan_off <= scan_off + LIMIT_W'(1);
      end
    end
    if (scan_rd) begin
      rd_cls <= scan_cls;
      rd_idx <= scan_addr;
    end
    if (rd_valid && !found && (rd_cls == req_cls) && ((rd_q == '0) || exp_fire)) begin
      free_idx <= rd_idx;
    end
    if (cmd.decide) begin
      status       <= dec_status;
      slot_granted <= dec_grant;
      slot_number  <= dec_grant ? free_idx : '0;
      class_in_use <= dec_inuse;
    end
  end

endmodule

/* rtl/core/per_class_request_limiter_unit.sv */
// Per-class request limiter: 32 classes, 512-slot timestamp store, one result per item.
// Per item: an expiry scan over all class slot ranges, one slot per cycle through the stamp memory
// port, a drain state for the last read and a decision state; a result still held by m_tready
// delays the decision. Items are taken one at a time: s_tready is high only between items.
// Reset: synchronous; a clearing pass over all 512 stamp memory slots follows, tready low.
module per_class_request_limiter_unit import pcrl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // request_class[7:0], now_seconds[39:8]
  input  logic [1:0]  s_tuser,  // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // slot_granted[0], slot_number[9:1], class_in_use[16:10]
  output logic [1:0]  m_tuser   // status[1:0]
);

  pcrl_cmd_t             cmd;
  pcrl_stat_t            stat;
  logic                  slot_granted;
  logic [SLOT_W-1:0]     slot_number;
  logic [COUNT_W-1:0]    class_in_use;
  logic [STATUS_W-1:0]   status;

  pcrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  pcrl_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_opcode    (s_tuser),
    .in_class     (s_tdata[7:0]),
    .in_now       (s_tdata[39:8]),
    .status       (status),
    .slot_granted (slot_granted),
    .slot_number  (slot_number),
    .class_in_use (class_in_use)
  );

  assign m_tdata = {7'd0, class_in_use, slot_number, slot_granted};
  assign m_tuser = status;

endmodule

/* rtl/core/pcrl_checker.sv */
// Port-level checker for the request limiter, bound to the top level
`include "per_class_request_limiter_unit_macros.svh"

module pcrl_checker import pcrl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser
);

  `PCRL_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "item taken while busy")
  `PCRL_ASSERT_IMPL(a_grant_ok, m_tvalid && m_tdata[0], m_tuser == STATUS_OK, "grant without ok")
  `PCRL_ASSERT_IMPL(a_no_grant_slot, m_tvalid && !m_tdata[0], m_tdata[9:1] == '0, "slot without grant")
  `PCRL_ASSERT_IMPL(a_invalid_clean, m_tvalid && (m_tuser == STATUS_INVALID), m_tdata[16:0] == '0, "invalid class result not clean")
  `PCRL_ASSERT_IMPL(a_unlimited_zero, m_tvalid && (m_tuser == STATUS_UNLIMITED), m_tdata[16:10] == '0, "unlimited class counted")

endmodule

bind per_class_request_limiter_unit pcrl_checker u_pcrl_checker (.*);

/* dv/tb.sv */
// Testbench for per_class_request_limiter_unit: directed and random requests checked against a predictor
module tb import pcrl_pkg::*; ();

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1145;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                granted;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  in_use;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // request_class[7:0], now_seconds[39:8]
  logic [1:0]  s_tuser = '0;  // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // slot_granted[0], slot_number[9:1], class_in_use[16:10]
  logic [1:0]  m_tuser;       // status[1:0]

  per_class_request_limiter_unit u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  int hold_secs [NUM_CLASSES] = '{
    5, 5, 10, 10, 5, 5, 5, 10, 5, 20, 20, 0, 0, 5, 20, 5,
    10, 10, 10, 10, 10, 10, 10, 5, 5, 2, 5, 5, 10, 10, 10, 10
  };
  int class_cap [NUM_CLASSES] = '{
    0, 20, 5, 5, 5, 30, 30, 10, 5, 1, 1, 0, 0, 10, 1, 10,
    20, 10, 20, 5, 2, 2, 2, 30, 0, 80, 40, 40, 5, 10, 10, 5
  };

  int                 slot_base [NUM_CLASSES];
  logic [NOW_W-1:0]   slot_stamp [NUM_SLOTS];
  logic [COUNT_W-1:0] in_flight [NUM_CLASSES];

  verdict_t pending_verdicts [$];

  int  error_count = 0;
  int  requests_sent = 0;
  int  results_seen = 0;
  int  grants_seen = 0;
  int  full_seen = 0;
  int  unlimited_seen = 0;
  int  invalid_seen = 0;
  bit  quiet_phase = 1'b0;
  int  stall_left = 0;
  logic [NOW_W-1:0] clock_s;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void reset_predictor();
    int acc;
    acc = 0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      slot_base[k] = acc;
      acc += class_cap[k];
      in_flight[k] = '0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) slot_stamp[i] = '0;
  endfunction

  function automatic verdict_t predict_verdict(input logic [OPCODE_W-1:0] op,
                                               input logic [CLASS_CODE_W-1:0] code,
                                               input logic [NOW_W-1:0] now);
    verdict_t         v;
    logic [NOW_W-1:0] hold;
    logic [NOW_W-1:0] s;
    int               idx;
    int               cap;
    int               c;
    bit               placed;
    v = '0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      hold = hold_secs[k];
      for (int e = 0; e < class_cap[k]; e++) begin
        idx = slot_base[k] + e;
        if (idx < NUM_SLOTS) begin
          s = slot_stamp[idx];
          if (s != '0 && hold <= now && s <= now - hold) begin
            slot_stamp[idx] = '0;
            in_flight[k] = in_flight[k] - COUNT_W'(1);
          end
        end
      end
    end
    if (code >= NUM_CLASSES) begin
      v.status = STATUS_INVALID;
    end else begin
      c = code;
      cap = class_cap[c];
      if (op == OP_CHECK || op == OP_ADMIT) begin
        if (cap == 0) v.status = STATUS_UNLIMITED;
        else if (in_flight[c] >= cap) v.status = STATUS_FULL;
        else v.status = STATUS_OK;
        if (op == OP_ADMIT && v.status == STATUS_OK) begin
          in_flight[c] = in_flight[c] + COUNT_W'(1);
          placed = 1'b0;
          for (int e = 0; e < cap; e++) begin
            idx = slot_base[c] + e;
            if (!placed && idx < NUM_SLOTS && slot_stamp[idx] == '0) begin
              slot_stamp[idx] = now;
              v.granted = 1'b1;
              v.slot = SLOT_W'(idx);
              placed = 1'b1;
            end
          end
        end
      end
      v.in_use = in_flight[c];
    end
    return v;
  endfunction

  function automatic int pick_gap(input int long_lo, input int long_hi);
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 5);
    return $urandom_range(long_lo, long_hi);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("tb: mismatch on %s: got %0d, want %0d (result %0d)",
               what, got, want, results_seen);
  endtask

  task automatic issue_request(input logic [OPCODE_W-1:0] op,
                               input logic [CLASS_CODE_W-1:0] code,
                               input logic [NOW_W-1:0] now);
    int gap;
    gap = pick_gap(20, 80);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {now, code};
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_verdicts.push_back(predict_verdict(op, code, now));
    requests_sent++;
  endtask

  task automatic drain_expected();
    if (pending_verdicts.size() != 0) begin
      s_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 99) < 8) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200)
                                                : $urandom_range(1, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("unexpected transaction", m_tdata, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tuser != want.status) flag_mismatch("status", m_tuser, want.status);
        if (m_tdata[0] != want.granted) flag_mismatch("slot_granted", m_tdata[0], want.granted);
        if (m_tdata[9:1] != want.slot) flag_mismatch("slot_number", m_tdata[9:1], want.slot);
        if (m_tdata[16:10] != want.in_use)
          flag_mismatch("class_in_use", m_tdata[16:10], want.in_use);
        if (want.granted) grants_seen++;
        if (want.status == STATUS_FULL) full_seen++;
        if (want.status == STATUS_UNLIMITED) unlimited_seen++;
        if (want.status == STATUS_INVALID) invalid_seen++;
      end
      results_seen++;
    end
  end

  task automatic test_directed_cases();
    logic [NOW_W-1:0] t;
    t = 32'd1000;
    issue_request(OP_CHECK, 8'd5, 32'd1);
    issue_request(OP_ADMIT, 8'd25, 32'd1);
    issue_request(OP_CHECK, 8'd25, 32'd3);
    issue_request(OP_CHECK, 8'd0, t);
    issue_request(OP_ADMIT, 8'd0, t);
    issue_request(OP_ADMIT, 8'd11, t);
    issue_request(OP_ADMIT, 8'd9, t);
    issue_request(OP_ADMIT, 8'd9, t);
    issue_request(OP_CHECK, 8'd9, t);
    issue_request(OP_EXPIRE, 8'd9, t);
    issue_request(OP_UNUSED, 8'd9, t);
    issue_request(OP_CHECK, 8'd32, t);
    issue_request(OP_ADMIT, 8'd255, t);
    issue_request(OP_EXPIRE, 8'd200, t);
    issue_request(OP_UNUSED, 8'd128, t);
    repeat (2) issue_request(OP_ADMIT, 8'd25, t);
    issue_request(OP_CHECK, 8'd25, t + 1);
    issue_request(OP_CHECK, 8'd25, t + 2);
    issue_request(OP_CHECK, 8'd9, t + 20);
    repeat (6) issue_request(OP_ADMIT, 8'd31, t + 20);
  endtask

  task automatic test_random_traffic();
    logic [OPCODE_W-1:0]     op;
    logic [CLASS_CODE_W-1:0] code;
    logic [NOW_W-1:0]        now;
    int                      hot;
    int                      r;
    clock_s = 32'd5000 + $urandom_range(0, 1000);
    hot = $urandom_range(0, NUM_CLASSES - 1);
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 350 || i == 800) drain_expected();
      quiet_phase = (i >= 500 && i < 600);
      if (i % 30 == 0) hot = $urandom_range(0, NUM_CLASSES - 1);
      r = $urandom_range(0, 99);
      if (r < 65) clock_s = clock_s;
      else if (r < 92) clock_s = clock_s + 1;
      else if (r < 98) clock_s = clock_s + $urandom_range(2, 6);
      else clock_s = clock_s + $urandom_range(10, 40);
      if ($urandom_range(0, 99) < 4) begin
        r = $urandom_range(0, 2);
        op = (r == 0) ? OP_CHECK : (r == 1) ? OP_EXPIRE : OP_UNUSED;
        code = CLASS_CODE_W'($urandom_range(0, 255));
        now = $urandom();
        if (now == '0) now = 32'd1;
      end else begin
        r = $urandom_range(0, 99);
        op = (r < 60) ? OP_ADMIT : (r < 85) ? OP_CHECK : (r < 95) ? OP_EXPIRE : OP_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 55) code = CLASS_CODE_W'(hot);
        else if (r < 90) code = CLASS_CODE_W'($urandom_range(0, NUM_CLASSES - 1));
        else code = CLASS_CODE_W'($urandom_range(NUM_CLASSES, 255));
        now = clock_s;
      end
      issue_request(op, code, now);
    end
    quiet_phase = 1'b0;
  endtask

  task automatic test_time_extremes();
    issue_request(OP_CHECK, 8'd1, 32'hFFFF_FFFF);
    issue_request(OP_ADMIT, 8'd25, 32'hFFFF_FFFE);
    issue_request(OP_EXPIRE, 8'd25, 32'hFFFF_FFFF);
    issue_request(OP_CHECK, 8'd25, 32'hFFFF_FFFF);
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic();
    test_time_extremes();
    drain_expected();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (450) @(posedge clk);
    if (pending_verdicts.size() != 0)
      flag_mismatch("results never delivered", pending_verdicts.size(), 0);
    $display("tb: %0d requests sent over all opcodes and class codes, %0d results checked",
             requests_sent, results_seen);
    $display("tb: verdicts seen: %0d granted, %0d full, %0d unlimited, %0d invalid",
             grants_seen, full_seen, unlimited_seen, invalid_seen);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
